// File: design/fzsc_pkg.sv
// Shared types and constants for the four-list zero-sum counter.
// Used by fzsc_ctrl, fzsc_dp and the top level; depends on nothing.
package fzsc_pkg;

	localparam int VAL_W = 32;
	localparam int SUM_W = 33;
	localparam int CNT_W = 17;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_COUNT = 1'b1;

	localparam logic [1:0] LIST_A = 2'd0;
	localparam logic [1:0] LIST_B = 2'd1;
	localparam logic [1:0] LIST_C = 2'd2;
	localparam logic [1:0] LIST_D = 2'd3;

	typedef struct packed {
		logic              command;
		logic [1:0]        list_select;
		logic signed [VAL_W-1:0] element_value;
	} req_t;

	typedef struct packed {
		logic [CNT_W-1:0] quadruple_count;
		logic             load_dropped;
	} rsp_t;

	// Commands from the sequencer to the datapath
	typedef struct packed {
		logic ld_wr;     // append the request value to a list
		logic drop_set;  // a load met a full list
		logic rd_en;     // read two list entries
		logic pair_wr;   // write a pair sum (takes effect in the datapath in the cycle after)
		logic ab_load;   // latch the A+B pair sum
		logic scan_rd;   // read one C+D pair sum for comparison
		logic cnt_clr;   // clear the running count
		logic out_load;  // load the result register
	} cmd_t;

endpackage

// File: design/four_list_zero_sum_count.sv
// Four-list zero-sum counter, top level.
// Request channel (req_valid / req_stall / req): a load request appends
// element_value to list A, B, C or D; a count request counts index
// quadruples whose values sum to zero, saturating at 131071.
// Response channel (rsp_valid / rsp_stall / rsp): one response per count
// request carrying the count and whether a load found its list full.
// Loads are taken one per cycle while no count is in progress, and give no
// response. A count request stalls the request side until its result is
// loaded; when a list is empty nothing is built or compared. The C+D pair
// sums are built into a memory one per cycle, then each A+B pair sum is
// compared against every stored sum, one memory read per cycle.
// The response sits in a register; a stalled response holds, and loads are
// still taken meanwhile; a further count finishes only once that slot frees.
// After a count the lists are emptied and the drop flag cleared.
// Reset empties all lists and clears the drop flag and response valid;
// memory contents are not cleared and need no clearing pass.
// Depends on fzsc_pkg, fzsc_ctrl and fzsc_dp.
module four_list_zero_sum_count #(
	parameter int MAX_LEN = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  fzsc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output fzsc_pkg::rsp_t rsp
);
	import fzsc_pkg::*;

	localparam int IW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int PAW = (MAX_LEN > 1) ? $clog2(MAX_LEN*MAX_LEN) : 1;

	cmd_t            cmd;
	logic [IW+1:0]   wr_addr, rd0_addr, rd1_addr;
	logic [PAW-1:0]  pair_addr;

	fzsc_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd0_addr  (rd0_addr),
		.rd1_addr  (rd1_addr),
		.pair_addr (pair_addr)
	);

	fzsc_dp #(.MAX_LEN(MAX_LEN)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.wr_addr   (wr_addr),
		.rd0_addr  (rd0_addr),
		.rd1_addr  (rd1_addr),
		.pair_addr (pair_addr),
		.rsp       (rsp)
	);

endmodule

// File: design/fzsc_dp.sv
// Datapath of the four-list zero-sum counter: list memory, pair-sum memory,
// adders, comparator and the saturating count. Depends on fzsc_pkg.
module fzsc_dp #(
	parameter int MAX_LEN = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fzsc_pkg::cmd_t       cmd,
	input  fzsc_pkg::req_t       req,
	input  logic [2+((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] wr_addr,
	input  logic [2+((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] rd0_addr,
	input  logic [2+((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] rd1_addr,
	input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN*MAX_LEN) : 1)-1:0] pair_addr,
	output fzsc_pkg::rsp_t       rsp
);
	import fzsc_pkg::*;

	localparam int IW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LAW = 2 + IW;
	localparam int PAW = (MAX_LEN > 1) ? $clog2(MAX_LEN*MAX_LEN) : 1;

	logic signed [VAL_W-1:0] list_mem [1<<LAW];
	logic signed [SUM_W-1:0] pair_mem [1<<PAW];

	logic signed [VAL_W-1:0] ra_q, rb_q;
	logic signed [SUM_W-1:0] ab_q, pd_q;
	logic                    pwr_s1, sv_s1;
	logic [PAW-1:0]          paddr_s1;
	logic [CNT_W-1:0]        cnt_q;
	logic                    drop_q;
	rsp_t                    rsp_q;
	logic signed [SUM_W-1:0] rsum;
	logic [SUM_W:0]          tot;

	// List memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.ld_wr) begin
			list_mem[wr_addr] <= req.element_value;
		end
		if (cmd.rd_en) begin
			ra_q <= list_mem[rd0_addr];
			rb_q <= list_mem[rd1_addr];
		end
	end

	assign rsum = {ra_q[VAL_W-1], ra_q} + {rb_q[VAL_W-1], rb_q};

	// Pair-sum memory: written in the cycle after the list read
	always_ff @(posedge clk) begin
		paddr_s1 <= pair_addr;
		if (pwr_s1) begin
			pair_mem[paddr_s1] <= rsum;
		end
		if (cmd.scan_rd) begin
			pd_q <= pair_mem[pair_addr];
		end
		if (cmd.ab_load) begin
			ab_q <= rsum;
		end
	end

	assign tot = {ab_q[SUM_W-1], ab_q} + {pd_q[SUM_W-1], pd_q};

	// Control flops, count and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwr_s1 <= 1'b0;
			sv_s1  <= 1'b0;
			cnt_q  <= '0;
			drop_q <= 1'b0;
		end else begin
			pwr_s1 <= cmd.pair_wr;
			sv_s1  <= cmd.scan_rd;
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (sv_s1 && tot == '0 && cnt_q != CNT_MAX) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.out_load) begin
				drop_q <= 1'b0;
			end else if (cmd.drop_set) begin
				drop_q <= 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.quadruple_count <= cnt_q;
			rsp_q.load_dropped    <= drop_q | cmd.drop_set;
		end
	end

	assign rsp = rsp_q;

	a_no_scan_during_build: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.scan_rd && cmd.pair_wr))
		else $error("pair memory read and written by the same phase");
	a_cnt_clr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_clr |=> cnt_q == '0)
		else $error("count not cleared");
	a_drop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> !drop_q)
		else $error("drop flag survived a result");

endmodule

// File: design/fzsc_ctrl.sv
// Sequencer of the four-list zero-sum counter: handshakes, list fill counts,
// loop counters and datapath commands. Depends on fzsc_pkg.
module fzsc_ctrl #(
	parameter int MAX_LEN = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  fzsc_pkg::req_t       req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output fzsc_pkg::cmd_t       cmd,
	output logic [2+((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] wr_addr,
	output logic [2+((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] rd0_addr,
	output logic [2+((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] rd1_addr,
	output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN*MAX_LEN) : 1)-1:0] pair_addr
);
	import fzsc_pkg::*;

	localparam int IW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int FW  = $clog2(MAX_LEN + 1);
	localparam int PAW = (MAX_LEN > 1) ? $clog2(MAX_LEN*MAX_LEN) : 1;
	localparam int PW  = $clog2(MAX_LEN*MAX_LEN + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_BUILD = 3'd2;
	localparam logic [2:0] S_ABRD  = 3'd3;
	localparam logic [2:0] S_ABSUM = 3'd4;
	localparam logic [2:0] S_SCAN  = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	logic [2:0]    state_q;
	logic [FW-1:0] fill_q [4];
	logic [IW-1:0] i_q, j_q, k_q, l_q;
	logic [PW-1:0] p_q;
	logic [PAW-1:0] q_q;
	logic          rsp_valid_q;
	logic          ld_acc, cnt_acc, full, any_empty, out_space;
	logic          last_i, last_j, last_k, last_l, last_q;

	assign req_stall = (state_q != S_IDLE);
	assign ld_acc    = req_valid && !req_stall && req.command == CMD_LOAD;
	assign cnt_acc   = req_valid && !req_stall && req.command == CMD_COUNT;
	assign full      = fill_q[req.list_select] == FW'(MAX_LEN);
	assign any_empty = fill_q[LIST_A] == '0 || fill_q[LIST_B] == '0 ||
		fill_q[LIST_C] == '0 || fill_q[LIST_D] == '0;
	assign out_space = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;

	assign last_i = FW'(i_q) == fill_q[LIST_A] - FW'(1);
	assign last_j = FW'(j_q) == fill_q[LIST_B] - FW'(1);
	assign last_k = FW'(k_q) == fill_q[LIST_C] - FW'(1);
	assign last_l = FW'(l_q) == fill_q[LIST_D] - FW'(1);
	assign last_q = PW'(q_q) == p_q - PW'(1);

	// Commands and addresses
	always_comb begin
		cmd.ld_wr    = ld_acc && !full;
		cmd.drop_set = ld_acc && full;
		cmd.rd_en    = state_q == S_BUILD || state_q == S_ABRD;
		cmd.pair_wr  = state_q == S_BUILD;
		cmd.ab_load  = state_q == S_ABSUM;
		cmd.scan_rd  = state_q == S_SCAN;
		cmd.cnt_clr  = cnt_acc;
		cmd.out_load = state_q == S_OUT && out_space;
		wr_addr      = {req.list_select, fill_q[req.list_select][IW-1:0]};
		if (state_q == S_BUILD) begin
			rd0_addr = {LIST_C, k_q};
			rd1_addr = {LIST_D, l_q};
			pair_addr = p_q[PAW-1:0];
		end else begin
			rd0_addr = {LIST_A, i_q};
			rd1_addr = {LIST_B, j_q};
			pair_addr = q_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '{default: '0};
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			l_q         <= '0;
			p_q         <= '0;
			q_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Response valid: set on a result load, dropped once taken
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.ld_wr) begin
						fill_q[req.list_select] <= fill_q[req.list_select] + FW'(1);
					end
					if (cnt_acc) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					k_q <= '0;
					l_q <= '0;
					p_q <= '0;
					state_q <= any_empty ? S_FIN : S_BUILD;
				end
				S_BUILD: begin
					p_q <= p_q + PW'(1);
					if (last_l) begin
						l_q <= '0;
						k_q <= k_q + IW'(1);
						if (last_k) begin
							i_q <= '0;
							j_q <= '0;
							state_q <= S_ABRD;
						end
					end else begin
						l_q <= l_q + IW'(1);
					end
				end
				S_ABRD: begin
					state_q <= S_ABSUM;
				end
				S_ABSUM: begin
					q_q <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					q_q <= q_q + PAW'(1);
					if (last_q) begin
						state_q <= (last_j && last_i) ? S_FIN : S_ABRD;
						if (last_j) begin
							j_q <= '0;
							i_q <= i_q + IW'(1);
						end else begin
							j_q <= j_q + IW'(1);
						end
					end
				end
				S_FIN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_space) begin
						fill_q      <= '{default: '0};
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q[LIST_A] <= FW'(MAX_LEN) && fill_q[LIST_D] <= FW'(MAX_LEN))
		else $error("list fill beyond capacity");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp_valid_q || !rsp_stall))
		else $error("result overwritten while stalled");
	a_result_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> rsp_valid_q && state_q == S_IDLE)
		else $error("result not presented");
	a_count_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_acc |=> state_q == S_START)
		else $error("count request not started");

endmodule

// File: tb/sv/four_list_zero_sum_count_test.sv
// Testbench for the four-list zero-sum counter: directed and random requests
// checked against a behavioural predictor. Depends on fzsc_pkg and the top level.
`timescale 1ns / 1ps

module four_list_zero_sum_count_test;
	import fzsc_pkg::*;

	localparam int LIST_LEN = 16;
	localparam int CYCLE_LIMIT = 4000000;

	class quad_count_board;
		logic signed [VAL_W-1:0] lists [4][$];
		bit drop_seen;
		rsp_t pending [$];
		int errors;
		int matched;

		function new();
			drop_seen = 0;
			errors = 0;
			matched = 0;
		endfunction

		// Counts zero-sum quadruples by brute force over the pair sums
		function automatic longint count_quads();
			longint total;
			longint cd_sums [$];
			longint ab;
			total = 0;
			for (int k = 0; k < lists[2].size(); k++)
				for (int l = 0; l < lists[3].size(); l++)
					cd_sums = {cd_sums, longint'(lists[2][k]) + longint'(lists[3][l])};
			for (int i = 0; i < lists[0].size(); i++)
				for (int j = 0; j < lists[1].size(); j++) begin
					ab = longint'(lists[0][i]) + longint'(lists[1][j]);
					foreach (cd_sums[m])
						if (ab + cd_sums[m] == 0)
							total++;
				end
			return total;
		endfunction

		function void note_request(req_t r);
			longint c;
			rsp_t e;
			if (r.command == CMD_LOAD) begin
				if (lists[r.list_select].size() >= LIST_LEN)
					drop_seen = 1;
				else
					lists[r.list_select] = {lists[r.list_select], r.element_value};
			end else begin
				c = count_quads();
				if (c > longint'(CNT_MAX))
					c = longint'(CNT_MAX);
				e.quadruple_count = CNT_W'(c);
				e.load_dropped = drop_seen;
				pending = {pending, e};
				for (int k = 0; k < 4; k++)
					lists[k].delete();
				drop_seen = 0;
			end
		endfunction

		task check_response(rsp_t got);
			rsp_t e;
			if (pending.size() == 0) begin
				report_mismatch("response with nothing expected");
				return;
			end
			e = pending.pop_front();
			if (got.quadruple_count !== e.quadruple_count)
				report_mismatch($sformatf("count %0d, expected %0d",
					got.quadruple_count, e.quadruple_count));
			if (got.load_dropped !== e.load_dropped)
				report_mismatch($sformatf("drop flag %0b, expected %0b",
					got.load_dropped, e.load_dropped));
			matched++;
		endtask

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	quad_count_board board;
	int sender_idle_pct;
	int receiver_stall_pct;
	int hold_off;
	int cycle_count;
	int sent_count;

	four_list_zero_sum_count #(.MAX_LEN(LIST_LEN)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial clk = 0;
	always #4 clk = ~clk;

	// Cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Response side: random stall, or a long hold-off when asked
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			board.check_response(rsp);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// Offers one request, idling first at random, and waits for acceptance
	task automatic send_request(logic cmd, logic [1:0] sel, logic [31:0] value);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req.command <= cmd;
		req.list_select <= sel;
		req.element_value <= value;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		board.note_request('{cmd, sel, value});
		sent_count++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] random_value();
		case ($urandom_range(4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($signed($urandom_range(6)) - 3);
			default: return $urandom();
		endcase
	endfunction

	// A well-formed set: short lists, often built to hit zero sums
	task automatic random_set(int max_len);
		int n;
		logic [31:0] v;
		n = $urandom_range(max_len);
		for (int k = 0; k < n; k++) begin
			v = random_value();
			if ($urandom_range(9) == 0)
				send_request(CMD_LOAD, 2'($urandom_range(3)), v);
			else begin
				send_request(CMD_LOAD, LIST_A, v);
				send_request(CMD_LOAD, LIST_B, 32'($urandom_range(4)));
				send_request(CMD_LOAD, LIST_C, -v);
				send_request(CMD_LOAD, LIST_D, -32'($urandom_range(4)));
			end
		end
		send_request(CMD_COUNT, LIST_A, $urandom());
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		hold_off = 0;
		cycle_count = 0;
		sent_count = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty lists, extremes, equal sums, full lists
		send_request(CMD_COUNT, LIST_D, 32'hFFFF_FFFF);
		send_request(CMD_LOAD, LIST_A, 32'h8000_0000);
		send_request(CMD_LOAD, LIST_B, 32'h8000_0000);
		send_request(CMD_LOAD, LIST_C, 32'h7FFF_FFFF);
		send_request(CMD_LOAD, LIST_D, 32'h7FFF_FFFF);
		send_request(CMD_COUNT, LIST_A, '0);
		send_request(CMD_LOAD, LIST_A, 32'h8000_0000);
		send_request(CMD_LOAD, LIST_B, 32'h7FFF_FFFF);
		send_request(CMD_LOAD, LIST_C, 32'h0000_0001);
		send_request(CMD_COUNT, LIST_A, '0);
		// All zeros and overfilled lists: largest count plus drops
		for (int k = 0; k < 4; k++)
			for (int m = 0; m < LIST_LEN + 1; m++)
				send_request(CMD_LOAD, 2'(k), '0);
		send_request(CMD_COUNT, LIST_A, '0);
		send_request(CMD_COUNT, LIST_A, '0);
		drain();

		// Random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			sender_idle_pct = (ph == 1) ? 77 : (ph == 3) ? 18 : 0;
			receiver_stall_pct = (ph == 2) ? 77 : (ph == 3) ? 18 : 0;
			for (int s = 0; s < 10; s++)
				random_set(3);
			if (ph == 0) begin
				// Long receiver hold-off while requests keep coming
				hold_off = 400;
				for (int s = 0; s < 6; s++)
					random_set(1);
			end
			drain();
		end
		receiver_stall_pct = 0;
		sender_idle_pct = 0;
		while (sent_count < 550)
			random_set(2);
		drain();
		repeat (50) @(posedge clk);

		$display("Ran %0d requests; %0d responses checked across idle and stall phases.",
			sent_count, board.matched);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// File: files.f
design/fzsc_pkg.sv
design/fzsc_dp.sv
design/fzsc_ctrl.sv
design/four_list_zero_sum_count.sv
tb/sv/four_list_zero_sum_count_test.sv
